/* rtl/pwm_alloc_pkg.sv */
package pwm_alloc_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int NUM_TIMERS = 4;

  localparam int CMD_W = 2;
  localparam int FREQ_W = 26;
  localparam int SLOT_W = 3;
  localparam int CLOCK_W = 27;
  localparam int STATUS_W = 2;
  localparam int DUTY_W = 4;
  localparam int USERS_W = 8;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TM_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int DUTY_MIN = 1;
  localparam int DUTY_MAX = 14;
  localparam int SHIFT_W = FREQ_W + DUTY_MAX;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd80000000;
  localparam logic [USERS_W-1:0] USERS_MAX = 8'd255;

  localparam logic [CMD_W-1:0] CMD_ALLOC_CH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE_CH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC_TM = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE_TM = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic accept;
    logic res_step;
    logic load_out;
  } pwm_alloc_cmd_t;

  typedef struct packed {
    logic need_res;
    logic res_last;
  } pwm_alloc_stat_t;

endpackage

/* rtl/pwm_alloc_ctrl.sv */
module pwm_alloc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  pwm_alloc_pkg::pwm_alloc_stat_t stat,
  output pwm_alloc_pkg::pwm_alloc_cmd_t  ctl
);
  import pwm_alloc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RES = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_next = stat.need_res ? S_RES : S_DONE;
        end
      end
      S_RES: begin
        ctl.res_step = 1'b1;
        if (stat.res_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pwm_alloc_dp.sv */
module pwm_alloc_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pwm_alloc_pkg::CLOCK_W-1:0]      source_clock_hz,
  input  logic [pwm_alloc_pkg::CMD_W-1:0]        cmd,
  input  logic [pwm_alloc_pkg::FREQ_W-1:0]       freq_hz,
  input  logic [pwm_alloc_pkg::SLOT_W-1:0]       slot_index,
  input  pwm_alloc_pkg::pwm_alloc_cmd_t          ctl,
  output pwm_alloc_pkg::pwm_alloc_stat_t         stat,
  output logic [pwm_alloc_pkg::STATUS_W-1:0]     status,
  output logic [pwm_alloc_pkg::SLOT_W-1:0]       granted_index,
  output logic [pwm_alloc_pkg::DUTY_W-1:0]       duty_bits
);
  import pwm_alloc_pkg::*;

  logic [CLOCK_W-1:0] clock_hz;
  logic [NUM_CHANNELS-1:0] channel_in_use;
  logic [FREQ_W-1:0] timer_frequency [NUM_TIMERS];
  logic [USERS_W-1:0] timer_users [NUM_TIMERS];

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0] res_grant;
  logic [DUTY_W-1:0] res_dbits;
  logic [SHIFT_W-1:0] shifted;
  logic [DUTY_W-1:0] step_k;

  logic ch_found;
  logic [SLOT_W-1:0] ch_grant;
  logic share_found;
  logic [SLOT_W-1:0] share_grant;
  logic free_found;
  logic [SLOT_W-1:0] free_grant;
  logic ch_in_range;
  logic tm_in_range;
  logic [CH_IDX_W-1:0] ch_slot;
  logic [TM_IDX_W-1:0] tm_slot;
  logic [TM_IDX_W-1:0] share_idx;
  logic [TM_IDX_W-1:0] free_idx;

  always_comb begin
    ch_found = 1'b0;
    ch_grant = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!channel_in_use[i]) begin
        ch_found = 1'b1;
        ch_grant = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    share_found = 1'b0;
    share_grant = '0;
    free_found = 1'b0;
    free_grant = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (timer_users[i] != '0 && timer_frequency[i] == freq_hz) begin
        share_found = 1'b1;
        share_grant = SLOT_W'(i);
      end
      if (timer_users[i] == '0) begin
        free_found = 1'b1;
        free_grant = SLOT_W'(i);
      end
    end
  end

  assign ch_in_range = ({1'b0, slot_index} < (SLOT_W + 1)'(NUM_CHANNELS));
  assign tm_in_range = ({1'b0, slot_index} < (SLOT_W + 1)'(NUM_TIMERS));
  assign ch_slot = slot_index[CH_IDX_W-1:0];
  assign tm_slot = slot_index[TM_IDX_W-1:0];
  assign share_idx = share_grant[TM_IDX_W-1:0];
  assign free_idx = free_grant[TM_IDX_W-1:0];

  assign stat.need_res = (cmd == CMD_ALLOC_TM) && (share_found || free_found);
  assign stat.res_last = (step_k == DUTY_W'(DUTY_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
      channel_in_use <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_frequency[i] <= '0;
        timer_users[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        clock_hz <= source_clock_hz;
      end
      if (ctl.accept) begin
        case (cmd)
          CMD_ALLOC_CH: begin
            if (ch_found) begin
              channel_in_use[ch_grant[CH_IDX_W-1:0]] <= 1'b1;
            end
          end
          CMD_FREE_CH: begin
            if (ch_in_range) begin
              channel_in_use[ch_slot] <= 1'b0;
            end
          end
          CMD_ALLOC_TM: begin
            if (share_found) begin
              if (timer_users[share_idx] != USERS_MAX) begin
                timer_users[share_idx] <= timer_users[share_idx] + 1'b1;
              end
            end else if (free_found) begin
              timer_frequency[free_idx] <= freq_hz;
              timer_users[free_idx] <= USERS_W'(1);
            end
          end
          default: begin
            if (tm_in_range && timer_users[tm_slot] != '0) begin
              timer_users[tm_slot] <= timer_users[tm_slot] - 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      shifted <= SHIFT_W'(freq_hz) << 1;
      step_k <= DUTY_W'(DUTY_MIN);
      case (cmd)
        CMD_ALLOC_CH: begin
          res_status <= ch_found ? STATUS_OK : STATUS_NONE_FREE;
          res_grant <= ch_found ? ch_grant : '0;
          res_dbits <= '0;
        end
        CMD_FREE_CH: begin
          res_status <= ch_in_range ? STATUS_OK : STATUS_RANGE;
          res_grant <= '0;
          res_dbits <= '0;
        end
        CMD_ALLOC_TM: begin
          if (share_found || free_found) begin
            res_status <= STATUS_OK;
            res_grant <= share_found ? share_grant : free_grant;
            res_dbits <= DUTY_W'(DUTY_MIN);
          end else begin
            res_status <= STATUS_NONE_FREE;
            res_grant <= '0;
            res_dbits <= '0;
          end
        end
        default: begin
          res_status <= tm_in_range ? STATUS_OK : STATUS_RANGE;
          res_grant <= '0;
          res_dbits <= '0;
        end
      endcase
    end else if (ctl.res_step) begin
      if (shifted <= SHIFT_W'(clock_hz)) begin
        res_dbits <= step_k;
      end
      shifted <= shifted << 1;
      step_k <= step_k + 1'b1;
    end
    if (ctl.load_out) begin
      status <= res_status;
      granted_index <= res_grant;
      duty_bits <= res_dbits;
    end
  end

endmodule

/* rtl/pwm_channel_timer_allocator.sv */
// Channel commands and timer frees go straight from acceptance to output load.
// A successful timer allocation runs the 14-step shift-compare duty resolution
// search between accept and output load.
// One transaction is in progress at a time; the output register holds a result
// while the next transaction's work runs. Synchronous reset clears all masks,
// counts and frequencies and sets the source clock to 80 MHz.
module pwm_channel_timer_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pwm_alloc_pkg::CLOCK_W-1:0]   source_clock_hz,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pwm_alloc_pkg::CMD_W-1:0]     cmd,
  input  logic [pwm_alloc_pkg::FREQ_W-1:0]    freq_hz,
  input  logic [pwm_alloc_pkg::SLOT_W-1:0]    slot_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pwm_alloc_pkg::STATUS_W-1:0]  status,
  output logic [pwm_alloc_pkg::SLOT_W-1:0]    granted_index,
  output logic [pwm_alloc_pkg::DUTY_W-1:0]    duty_bits
);
  import pwm_alloc_pkg::*;

  pwm_alloc_cmd_t ctl;
  pwm_alloc_stat_t stat;

  pwm_alloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pwm_alloc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .source_clock_hz (source_clock_hz),
    .cmd             (cmd),
    .freq_hz         (freq_hz),
    .slot_index      (slot_index),
    .ctl             (ctl),
    .stat            (stat),
    .status          (status),
    .granted_index   (granted_index),
    .duty_bits       (duty_bits)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction was in progress");

  a_grant_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> granted_index == '0 && duty_bits == '0)
    else $error("failed transaction reports a grant or duty resolution");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_bits != '0 |-> duty_bits <= DUTY_W'(DUTY_MAX))
    else $error("duty resolution out of range");
`endif

endmodule
